FILE: rtl/wit_pkg.sv
// ----------------------------------------------------------------------------
// Whitespace instruction tokenizer package
// Transaction types, opcode numbering and status codes shared by the block.
// ----------------------------------------------------------------------------
package wit_pkg;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         opcode;
    logic               has_argument;
    logic signed [31:0] argument;
    logic [1:0]         status;
  } out_item_t;

  // Decoder result toward the output register.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } dec_res_t;

  localparam logic [4:0] OP_PUSH        = 5'd0;
  localparam logic [4:0] OP_DUPLICATE   = 5'd1;
  localparam logic [4:0] OP_SWAP        = 5'd2;
  localparam logic [4:0] OP_DISCARD     = 5'd3;
  localparam logic [4:0] OP_COPY        = 5'd4;
  localparam logic [4:0] OP_SLIDE       = 5'd5;
  localparam logic [4:0] OP_ADD         = 5'd6;
  localparam logic [4:0] OP_SUBTRACT    = 5'd7;
  localparam logic [4:0] OP_MULTIPLY    = 5'd8;
  localparam logic [4:0] OP_DIVIDE      = 5'd9;
  localparam logic [4:0] OP_MODULO      = 5'd10;
  localparam logic [4:0] OP_STORE       = 5'd11;
  localparam logic [4:0] OP_RETRIEVE    = 5'd12;
  localparam logic [4:0] OP_MARK        = 5'd13;
  localparam logic [4:0] OP_CALL        = 5'd14;
  localparam logic [4:0] OP_JUMP        = 5'd15;
  localparam logic [4:0] OP_JUMP_ZERO   = 5'd16;
  localparam logic [4:0] OP_JUMP_NEG    = 5'd17;
  localparam logic [4:0] OP_RETURN      = 5'd18;
  localparam logic [4:0] OP_END         = 5'd19;
  localparam logic [4:0] OP_WRITE_CHAR  = 5'd20;
  localparam logic [4:0] OP_WRITE_NUM   = 5'd21;
  localparam logic [4:0] OP_READ_CHAR   = 5'd22;
  localparam logic [4:0] OP_READ_NUM    = 5'd23;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

endpackage

FILE: rtl/wit_decoder.sv
// ----------------------------------------------------------------------------
// Whitespace instruction decoder
// Holds the prefix-tree phase and argument accumulator, and advances them by
// one source byte per step, producing at most one result per byte.
// ----------------------------------------------------------------------------
module wit_decoder #(
  parameter int ARG_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  wit_pkg::in_item_t  item,
  output wit_pkg::dec_res_t  res
);
  import wit_pkg::*;

  localparam int MAG_W  = ARG_BITS - 1;
  localparam int WIDE_W = (ARG_BITS > 32) ? ARG_BITS : 32;

  localparam logic [1:0] SYM_SPACE   = 2'd0;
  localparam logic [1:0] SYM_TAB     = 2'd1;
  localparam logic [1:0] SYM_NEWLINE = 2'd2;

  typedef enum logic [4:0] {
    PH_START, PH_T, PH_STACK, PH_STACK_L, PH_STACK_T, PH_ARITH, PH_ARITH_S,
    PH_ARITH_T, PH_HEAP, PH_FLOW, PH_FLOW_S, PH_FLOW_T, PH_FLOW_L, PH_IO,
    PH_IO_S, PH_IO_T, PH_SIGN, PH_DIGITS
  } phase_t;

  typedef struct packed {
    logic       bad;
    logic       is_cmd;
    phase_t     nxt;
    logic [4:0] op;
  } tree_ent_t;

  function automatic tree_ent_t go(input phase_t ph);
    tree_ent_t e;
    e = '{bad: 1'b0, is_cmd: 1'b0, nxt: ph, op: OP_PUSH};
    return e;
  endfunction

  function automatic tree_ent_t cmd(input logic [4:0] op);
    tree_ent_t e;
    e = '{bad: 1'b0, is_cmd: 1'b1, nxt: PH_START, op: op};
    return e;
  endfunction

  function automatic tree_ent_t bad();
    tree_ent_t e;
    e = '{bad: 1'b1, is_cmd: 1'b0, nxt: PH_START, op: OP_PUSH};
    return e;
  endfunction

  // Three-way choice on the symbol: space, tab, newline.
  function automatic tree_ent_t pick(input logic [1:0] sym, input tree_ent_t s,
                                     input tree_ent_t t, input tree_ent_t n);
    tree_ent_t e;
    case (sym)
      SYM_SPACE: e = s;
      SYM_TAB:   e = t;
      default:   e = n;
    endcase
    return e;
  endfunction

  function automatic tree_ent_t tree_step(input phase_t ph, input logic [1:0] sym);
    tree_ent_t e;
    case (ph)
      PH_START:   e = pick(sym, go(PH_STACK), go(PH_T), go(PH_FLOW));
      PH_T:       e = pick(sym, go(PH_ARITH), go(PH_HEAP), go(PH_IO));
      PH_STACK:   e = pick(sym, cmd(OP_PUSH), go(PH_STACK_T), go(PH_STACK_L));
      PH_STACK_L: e = pick(sym, cmd(OP_DUPLICATE), cmd(OP_SWAP), cmd(OP_DISCARD));
      PH_STACK_T: e = pick(sym, cmd(OP_COPY), bad(), cmd(OP_SLIDE));
      PH_ARITH:   e = pick(sym, go(PH_ARITH_S), go(PH_ARITH_T), bad());
      PH_ARITH_S: e = pick(sym, cmd(OP_ADD), cmd(OP_SUBTRACT), cmd(OP_MULTIPLY));
      PH_ARITH_T: e = pick(sym, cmd(OP_DIVIDE), cmd(OP_MODULO), bad());
      PH_HEAP:    e = pick(sym, cmd(OP_STORE), cmd(OP_RETRIEVE), bad());
      PH_FLOW:    e = pick(sym, go(PH_FLOW_S), go(PH_FLOW_T), go(PH_FLOW_L));
      PH_FLOW_S:  e = pick(sym, cmd(OP_MARK), cmd(OP_CALL), cmd(OP_JUMP));
      PH_FLOW_T:  e = pick(sym, cmd(OP_JUMP_ZERO), cmd(OP_JUMP_NEG), cmd(OP_RETURN));
      PH_FLOW_L:  e = pick(sym, bad(), bad(), cmd(OP_END));
      PH_IO:      e = pick(sym, go(PH_IO_S), go(PH_IO_T), bad());
      PH_IO_S:    e = pick(sym, cmd(OP_WRITE_CHAR), cmd(OP_WRITE_NUM), bad());
      PH_IO_T:    e = pick(sym, cmd(OP_READ_CHAR), cmd(OP_READ_NUM), bad());
      default:    e = bad();
    endcase
    return e;
  endfunction

  function automatic logic takes_argument(input logic [4:0] op);
    return (op == OP_PUSH) || (op == OP_COPY) || (op == OP_SLIDE) ||
           (op == OP_MARK) || (op == OP_CALL) || (op == OP_JUMP) ||
           (op == OP_JUMP_ZERO) || (op == OP_JUMP_NEG);
  endfunction

  phase_t            phase_r, phase_nxt;
  logic [4:0]        pending_r, pending_nxt;
  logic              neg_r, neg_nxt;
  logic [MAG_W-1:0]  mag_r, mag_nxt;
  logic              ovf_r, ovf_nxt;

  logic              is_sym;
  logic [1:0]        sym;
  tree_ent_t         ent;
  logic [ARG_BITS-1:0] value;
  logic [WIDE_W-1:0] value_ext;

  always_comb begin
    is_sym = 1'b1;
    sym    = SYM_SPACE;
    case (item.source_byte)
      8'd32:   sym = SYM_SPACE;
      8'd9:    sym = SYM_TAB;
      8'd10:   sym = SYM_NEWLINE;
      default: is_sym = 1'b0;
    endcase
  end

  assign ent       = tree_step(phase_r, sym);
  assign value     = neg_r ? (ARG_BITS'(0) - {1'b0, mag_r}) : {1'b0, mag_r};
  assign value_ext = WIDE_W'($signed(value));

  always_comb begin
    phase_nxt   = phase_r;
    pending_nxt = pending_r;
    neg_nxt     = neg_r;
    mag_nxt     = mag_r;
    ovf_nxt     = ovf_r;
    res         = '0;

    if (is_sym) begin
      case (phase_r)
        PH_SIGN: begin
          if (sym == SYM_NEWLINE) begin
            res.valid       = 1'b1;
            res.item.status = ST_INVALID;
            phase_nxt       = PH_START;
          end else begin
            neg_nxt   = (sym == SYM_TAB);
            phase_nxt = PH_DIGITS;
          end
        end
        PH_DIGITS: begin
          if (sym == SYM_NEWLINE) begin
            res.valid             = 1'b1;
            res.item.opcode       = pending_r;
            res.item.has_argument = 1'b1;
            res.item.status       = ovf_r ? ST_OVERFLOW : ST_OK;
            res.item.argument     = ovf_r ? 32'sd0 : $signed(value_ext[31:0]);
            phase_nxt             = PH_START;
          end else if (!ovf_r) begin
            // Top magnitude bit set means one more digit exceeds the positive limit.
            if (mag_r[MAG_W-1]) begin
              ovf_nxt = 1'b1;
            end else begin
              mag_nxt = {mag_r[MAG_W-2:0], (sym == SYM_TAB)};
            end
          end
        end
        default: begin
          if (ent.bad) begin
            res.valid       = 1'b1;
            res.item.status = ST_INVALID;
            phase_nxt       = PH_START;
          end else if (ent.is_cmd) begin
            if (takes_argument(ent.op)) begin
              pending_nxt = ent.op;
              neg_nxt     = 1'b0;
              mag_nxt     = '0;
              ovf_nxt     = 1'b0;
              phase_nxt   = PH_SIGN;
            end else begin
              res.valid       = 1'b1;
              res.item.opcode = ent.op;
              phase_nxt       = PH_START;
            end
          end else begin
            phase_nxt = ent.nxt;
          end
        end
      endcase
    end

    if (item.end_of_stream) begin
      if (!res.valid && (phase_nxt != PH_START)) begin
        res.valid       = 1'b1;
        res.item.status = ST_TRUNCATED;
      end
      phase_nxt = PH_START;
    end

    // Any finished instruction or error returns the decoder to a clean start.
    if (phase_nxt == PH_START) begin
      pending_nxt = OP_PUSH;
      neg_nxt     = 1'b0;
      mag_nxt     = '0;
      ovf_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      pending_r <= OP_PUSH;
      neg_r     <= 1'b0;
      mag_r     <= '0;
      ovf_r     <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      pending_r <= pending_nxt;
      neg_r     <= neg_nxt;
      mag_r     <= mag_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

endmodule

FILE: rtl/whitespace_instruction_tokenizer.sv
// ----------------------------------------------------------------------------
// Whitespace instruction tokenizer
// Turns a stream of source bytes into decoded instructions with arguments.
// ----------------------------------------------------------------------------
// The block takes one source byte per clock while in_stall is low and
// returns at most one instruction transaction per byte. A byte passes from an
// input register through the decoder into an output register; the decoder
// state updates as the result is registered, so a steady stream runs at one
// byte per cycle while the output is not stalled. Bytes other than space, tab
// and newline are ignored as symbols, though their end-of-stream mark counts.
// Errors and truncation come out as nonzero-status transactions and restart decoding.
module whitespace_instruction_tokenizer #(
  parameter int ARG_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wit_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output wit_pkg::out_item_t out_item
);
  import wit_pkg::*;

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      advance;
  dec_res_t  dec_res;

  // The held byte is decoded once the output register can take its result.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  wit_decoder #(
    .ARG_BITS(ARG_BITS)
  ) u_decoder (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_item_r),
    .res   (dec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= dec_res.valid;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
    if (advance && dec_res.valid) begin
      out_item_r <= dec_res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: rtl/wit_checker.sv
// ----------------------------------------------------------------------------
// Whitespace instruction tokenizer checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module wit_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input wit_pkg::out_item_t out_item
);
  import wit_pkg::*;

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_INVALID || out_item.status == ST_TRUNCATED)
    |-> out_item.opcode == OP_PUSH && !out_item.has_argument && out_item.argument == 0)
    else $error("error transaction carries a command");

  a_ovf_arg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_OVERFLOW
    |-> out_item.has_argument && out_item.argument == 0)
    else $error("overflow transaction malformed");

  a_no_arg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.has_argument |-> out_item.argument == 0)
    else $error("argument without has_argument");

  a_opcode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.opcode <= OP_READ_NUM)
    else $error("opcode out of range");

endmodule

bind whitespace_instruction_tokenizer wit_checker u_wit_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Whitespace instruction tokenizer testbench
// Streams source bytes into the tokenizer and checks every decoded
// instruction against a cycle-free prediction kept in a scoreboard. A short
// hand-built byte sequence comes first. Random instructions follow, mixed with
// noise, broken sequences, end-of-stream marks and long arguments, while both
// sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import wit_pkg::*;

  localparam int ARG_BITS = 32;
  localparam longint unsigned ARG_LIMIT = (64'd1 << (ARG_BITS - 1)) - 1;
  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 9;
  localparam int SYMBOL_TARGET = 1550;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT_CYCLES = 300_000;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF = 8'd10;

  typedef enum int {SYM_SPACE, SYM_TAB, SYM_LF, SYM_NONE} symbol_t;

  typedef enum logic [4:0] {
    DP_START, DP_T, DP_STACK, DP_STACK_L, DP_STACK_T, DP_ARITH, DP_ARITH_S,
    DP_ARITH_T, DP_HEAP, DP_FLOW, DP_FLOW_S, DP_FLOW_T, DP_FLOW_L, DP_IO,
    DP_IO_S, DP_IO_T, DP_SIGN, DP_DIGITS
  } decode_phase_t;

  function automatic symbol_t symbol_of(logic [7:0] b);
    case (b)
      CH_SPACE: return SYM_SPACE;
      CH_TAB:   return SYM_TAB;
      CH_LF:    return SYM_LF;
      default:  return SYM_NONE;
    endcase
  endfunction

  // Predicts the decoded instructions from the accepted byte stream and
  // matches them against what the block returns.
  class token_scoreboard;
    out_item_t     expected_tokens[$];
    decode_phase_t phase;
    logic [4:0]    pending_op;
    bit            negative;
    longint unsigned magnitude;
    bit            overflowed;
    int            fails;
    int            checked;
    int            bytes_seen;
    int            status_count[4];
    bit            opcode_seen[24];

    function new();
      restart();
    endfunction

    function void restart();
      phase = DP_START;
      pending_op = OP_PUSH;
      negative = 1'b0;
      magnitude = 0;
      overflowed = 1'b0;
    endfunction

    static function bit needs_arg(logic [4:0] op);
      return op == OP_PUSH || op == OP_COPY || op == OP_SLIDE ||
             (op >= OP_MARK && op <= OP_JUMP_NEG);
    endfunction

    static function logic [4:0] pick_op(symbol_t s, logic [4:0] a, logic [4:0] b,
                                        logic [4:0] c);
      return (s == SYM_SPACE) ? a : (s == SYM_TAB) ? b : c;
    endfunction

    static function decode_phase_t pick_phase(symbol_t s, decode_phase_t a,
                                              decode_phase_t b, decode_phase_t c);
      return (s == SYM_SPACE) ? a : (s == SYM_TAB) ? b : c;
    endfunction

    function void expect_token(logic [4:0] op, bit has, logic [31:0] arg,
                               logic [1:0] st);
      out_item_t t;
      t.opcode = op;
      t.has_argument = has;
      t.argument = arg;
      t.status = st;
      expected_tokens = {expected_tokens, t};
    endfunction

    function void note_byte(in_item_t it);
      symbol_t s;
      bit made;
      bit bad;
      bit is_cmd;
      logic [4:0] op;
      decode_phase_t nxt;
      longint unsigned digit;
      logic [31:0] val;
      s = symbol_of(it.source_byte);
      made = 1'b0;
      bytes_seen++;
      if (s != SYM_NONE) begin
        if (phase == DP_SIGN) begin
          if (s == SYM_LF) begin
            expect_token(OP_PUSH, 1'b0, '0, ST_INVALID);
            made = 1'b1;
            restart();
          end else begin
            negative = (s == SYM_TAB);
            phase = DP_DIGITS;
          end
        end else if (phase == DP_DIGITS) begin
          if (s == SYM_LF) begin
            if (overflowed) begin
              expect_token(pending_op, 1'b1, '0, ST_OVERFLOW);
            end else begin
              val = magnitude[31:0];
              expect_token(pending_op, 1'b1, negative ? -val : val, ST_OK);
            end
            made = 1'b1;
            restart();
          end else if (!overflowed) begin
            digit = (s == SYM_TAB);
            // Once the magnitude would pass the limit, later digits are dropped.
            if (magnitude > (ARG_LIMIT - digit) / 2) overflowed = 1'b1;
            else magnitude = magnitude * 2 + digit;
          end
        end else begin
          bad = 1'b0;
          is_cmd = 1'b1;
          op = OP_PUSH;
          nxt = phase;
          case (phase)
            DP_START: begin
              is_cmd = 1'b0;
              nxt = pick_phase(s, DP_STACK, DP_T, DP_FLOW);
            end
            DP_T: begin
              is_cmd = 1'b0;
              nxt = pick_phase(s, DP_ARITH, DP_HEAP, DP_IO);
            end
            DP_STACK: begin
              if (s != SYM_SPACE) begin
                is_cmd = 1'b0;
                nxt = pick_phase(s, DP_STACK, DP_STACK_T, DP_STACK_L);
              end
            end
            DP_STACK_L: op = pick_op(s, OP_DUPLICATE, OP_SWAP, OP_DISCARD);
            DP_STACK_T: begin
              bad = (s == SYM_TAB);
              op = pick_op(s, OP_COPY, OP_COPY, OP_SLIDE);
            end
            DP_ARITH: begin
              bad = (s == SYM_LF);
              is_cmd = 1'b0;
              nxt = pick_phase(s, DP_ARITH_S, DP_ARITH_T, DP_ARITH_T);
            end
            DP_ARITH_S: op = pick_op(s, OP_ADD, OP_SUBTRACT, OP_MULTIPLY);
            DP_ARITH_T: begin
              bad = (s == SYM_LF);
              op = pick_op(s, OP_DIVIDE, OP_MODULO, OP_MODULO);
            end
            DP_HEAP: begin
              bad = (s == SYM_LF);
              op = pick_op(s, OP_STORE, OP_RETRIEVE, OP_RETRIEVE);
            end
            DP_FLOW: begin
              is_cmd = 1'b0;
              nxt = pick_phase(s, DP_FLOW_S, DP_FLOW_T, DP_FLOW_L);
            end
            DP_FLOW_S: op = pick_op(s, OP_MARK, OP_CALL, OP_JUMP);
            DP_FLOW_T: op = pick_op(s, OP_JUMP_ZERO, OP_JUMP_NEG, OP_RETURN);
            DP_FLOW_L: begin
              bad = (s != SYM_LF);
              op = OP_END;
            end
            DP_IO: begin
              bad = (s == SYM_LF);
              is_cmd = 1'b0;
              nxt = pick_phase(s, DP_IO_S, DP_IO_T, DP_IO_T);
            end
            DP_IO_S: begin
              bad = (s == SYM_LF);
              op = pick_op(s, OP_WRITE_CHAR, OP_WRITE_NUM, OP_WRITE_NUM);
            end
            DP_IO_T: begin
              bad = (s == SYM_LF);
              op = pick_op(s, OP_READ_CHAR, OP_READ_NUM, OP_READ_NUM);
            end
            default: bad = 1'b1;
          endcase
          if (bad) begin
            expect_token(OP_PUSH, 1'b0, '0, ST_INVALID);
            made = 1'b1;
            restart();
          end else if (is_cmd && needs_arg(op)) begin
            pending_op = op;
            negative = 1'b0;
            magnitude = 0;
            overflowed = 1'b0;
            phase = DP_SIGN;
          end else if (is_cmd) begin
            expect_token(op, 1'b0, '0, ST_OK);
            made = 1'b1;
            restart();
          end else begin
            phase = nxt;
          end
        end
      end
      if (it.end_of_stream) begin
        if (!made && phase != DP_START) expect_token(OP_PUSH, 1'b0, '0, ST_TRUNCATED);
        restart();
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_tokens.size() == 0) begin
        $error("unexpected result: opcode %0d, argument %0d, status %0d",
               got.opcode, got.argument, got.status);
        fails++;
        return;
      end
      want = expected_tokens.pop_front();
      if (got.opcode !== want.opcode) begin
        $error("opcode: expected %0d, actual %0d", want.opcode, got.opcode);
        fails++;
      end
      if (got.has_argument !== want.has_argument) begin
        $error("has_argument: expected %0d, actual %0d", want.has_argument,
               got.has_argument);
        fails++;
      end
      if (got.argument !== want.argument) begin
        $error("argument: expected %0d, actual %0d", want.argument, got.argument);
        fails++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        fails++;
      end
      checked++;
      status_count[want.status]++;
      if (want.status == ST_OK) opcode_seen[want.opcode] = 1'b1;
    endfunction
  endclass

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  token_scoreboard board = new();

  // Spelling of each instruction in the tree: S space, T tab, L newline.
  string op_spelling[24] = '{
    "SS", "SLS", "SLT", "SLL", "STS", "STL", "TSSS", "TSST", "TSSL", "TSTS",
    "TSTT", "TTS", "TTT", "LSS", "LST", "LSL", "LTS", "LTT", "LTL", "LLL",
    "TLSS", "TLST", "TLTS", "TLTT"
  };

  in_item_t burst[$];
  bit       quiet_stretch = 1'b0;
  bit       noise_on = 1'b0;
  int       symbols_sent = 0;
  bit       hold_done = 1'b0;

  whitespace_instruction_tokenizer #(
    .ARG_BITS(ARG_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_byte(in_item);
      if (out_valid && !out_stall) board.check_result(out_item);
    end
  end

  function automatic bit take_break();
    return !quiet_stretch && ($urandom_range(99) < 36);
  endfunction

  function automatic logic [7:0] byte_of(symbol_t s);
    case (s)
      SYM_SPACE: return CH_SPACE;
      SYM_TAB:   return CH_TAB;
      default:   return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (symbol_of(b) != SYM_NONE);
    return b;
  endfunction

  function automatic void add_byte(logic [7:0] b);
    in_item_t it;
    it.source_byte = b;
    it.end_of_stream = 1'b0;
    burst = {burst, it};
  endfunction

  function automatic void add_sym(symbol_t s);
    if (noise_on && $urandom_range(9) == 0) add_byte(noise_byte());
    add_byte(byte_of(s));
  endfunction

  function automatic void mark_end();
    burst[burst.size() - 1].end_of_stream = 1'b1;
  endfunction

  function automatic void add_spelling(string text);
    for (int i = 0; i < text.len(); i++)
      add_sym(text[i] == "S" ? SYM_SPACE : text[i] == "T" ? SYM_TAB : SYM_LF);
  endfunction

  // One well-formed instruction; long arguments hit the limit exactly or run to a length near it, either side.
  function automatic void add_instruction(logic [4:0] op);
    int digits;
    int tab_pct;
    add_spelling(op_spelling[op]);
    if (token_scoreboard::needs_arg(op)) begin
      add_sym($urandom_range(1) ? SYM_TAB : SYM_SPACE);
      if ($urandom_range(7) == 0) begin
        if ($urandom_range(2) == 0) begin
          digits = ARG_BITS - 1;
          tab_pct = 100;
        end else begin
          digits = $urandom_range(ARG_BITS - 4, ARG_BITS + 4);
          tab_pct = 85;
        end
      end else begin
        digits = $urandom_range(0, 12);
        tab_pct = 50;
      end
      for (int i = 0; i < digits; i++)
        add_sym(($urandom_range(99) < tab_pct) ? SYM_TAB : SYM_SPACE);
      add_sym(SYM_LF);
    end
  endfunction

  task automatic send_byte(in_item_t it);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    symbols_sent++;
  endtask

  task automatic send_burst();
    foreach (burst[i]) send_byte(burst[i]);
    burst.delete();
  endtask

  // Receiver: random stalls, plus one long hold so the block backs up.
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      if (!hold_done && symbols_sent >= 300) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= take_break();
      @(posedge clk);
    end
  end

  initial begin
    int kind;
    @(posedge clk iff rst_n);

    // Ignored extremes, negative zero, a dead branch, newline in place of a
    // sign, truncation, a lone skipped byte at end of stream, an end command
    // that closes the stream, and a small negative label.
    add_byte(8'h00);
    add_byte(8'hFF);
    add_spelling("SSTSL");
    add_spelling("STT");
    add_spelling("SSL");
    add_spelling("TS");
    mark_end();
    add_byte(8'h41);
    mark_end();
    add_spelling("LLL");
    mark_end();
    add_spelling("LTTTTL");
    send_burst();

    while (symbols_sent < SYMBOL_TARGET) begin
      quiet_stretch = (symbols_sent >= 700 && symbols_sent < 950);
      noise_on = ($urandom_range(3) == 0);
      kind = $urandom_range(99);
      if (kind < 70) begin
        add_instruction(5'($urandom_range(23)));
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(255)));
        if ($urandom_range(3) == 0) mark_end();
      end else if (kind < 92) begin
        repeat ($urandom_range(1, 5)) add_sym(symbol_t'($urandom_range(2)));
      end else begin
        // End of stream somewhere inside an instruction, or right on its end.
        add_instruction(5'($urandom_range(23)));
        burst[$urandom_range(burst.size() - 1)].end_of_stream = 1'b1;
      end
      send_burst();
    end
    in_valid <= 1'b0;
    quiet_stretch = 1'b0;

    while (board.expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d results from %0d bytes: %0d ok, %0d invalid, %0d overflow, %0d truncated.",
             board.checked, board.bytes_seen, board.status_count[ST_OK],
             board.status_count[ST_INVALID], board.status_count[ST_OVERFLOW],
             board.status_count[ST_TRUNCATED]);
    $display("Instructions decoded cleanly for %0d of 24 opcodes.",
             board.opcode_seen.sum() with (int'(item)));
    if (board.fails == 0) begin
      $display("whitespace_instruction_tokenizer test passed");
    end else begin
      $display("whitespace_instruction_tokenizer test failed");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("whitespace_instruction_tokenizer test failed");
    $finish;
  end

endmodule
